// File: src/assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: src/ddt_pkg.sv
package ddt_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DIFF,
		ST_SAT,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam int REG_INDEX_BITS = 1;

	localparam logic [REG_INDEX_BITS-1:0] REG_INITIAL_EQUITY = 1'b0;
	localparam logic [REG_INDEX_BITS-1:0] REG_DRAWDOWN_LIMIT = 1'b1;

endpackage

// File: src/drawdown_tracker_with_halt.sv
// Drawdown tracker with halt latch. Each input word carries one signed equity sample; the
// block keeps a running peak that only rises and returns one result word per sample: the
// peak after the sample, the drawdown (peak - sample) / peak as an unsigned ratio with
// FRACTION_BITS fraction bits and one integer bit (floor, 0 when the peak is not positive,
// all ones at 2.0 or more), the worst drawdown so far, the halt latch and a halt_now pulse
// on the sample that first reaches drawdown_limit. Writing initial_equity reloads the peak
// and clears the worst drawdown and the halt latch. One subtractor does all the work under a
// small sequencer, restoring one quotient bit per cycle: an accepted sample passes the compare,
// difference, saturation and divide steps to the finish step, which it reaches straight from the
// difference step when the peak is not positive and from the saturation step when the ratio
// saturates. The input side is ready only while the sequencer is idle; a finished result waits
// in the output register while the next sample is taken, and the sequencer holds its last step
// while the previous result has not been taken.
`include "assert_macros.svh"

module drawdown_tracker_with_halt #(
	parameter int EQUITY_BITS   = 48,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ddt_pkg::REG_INDEX_BITS-1:0]     cfg_index,
	input  logic [((EQUITY_BITS > FRACTION_BITS + 1) ?
		EQUITY_BITS : FRACTION_BITS + 1)-1:0]      cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// equity
	input  logic [((EQUITY_BITS + 7) / 8) * 8-1:0] s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// peak, drawdown, worst_drawdown, halted, halt_now
	output logic [((EQUITY_BITS + 2 * FRACTION_BITS + 4 + 7) / 8) * 8-1:0] m_tdata
);

	localparam int EW      = EQUITY_BITS;
	localparam int RW      = FRACTION_BITS + 1;
	localparam int OUT_RAW = EW + 2 * RW + 2;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
	localparam int CNT_W   = $clog2(RW);

	localparam logic [EW-1:0] SIGN_BIT  = {1'b1, {(EW-1){1'b0}}};
	localparam logic [RW-1:0] LIMIT_RST = {1'b0, {FRACTION_BITS{1'b1}}};

	ddt_pkg::state_t state_q, state_d;

	logic [EW-1:0]    peak_q;
	logic [RW-1:0]    worst_q;
	logic             halt_q;
	logic [RW-1:0]    limit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;

	logic [EW-1:0] sample_q;
	logic [EW-1:0] rem_q;
	logic [RW-1:0] quo_q;

	logic [EW-1:0] out_peak_q;
	logic [RW-1:0] out_dd_q;
	logic [RW-1:0] out_worst_q;
	logic          out_halted_q;
	logic          out_now_q;

	logic [EW-1:0] op_a, op_b;
	logic [EW:0]   sub;
	logic          borrow;
	logic          fin_go;
	logic          peak_nonpos;
	logic          div_last;
	logic          halt_set;
	logic [RW-1:0] worst_d;

	// shared subtractor
	assign sub    = {1'b0, op_a} - {1'b0, op_b};
	assign borrow = sub[EW];

	assign peak_nonpos = peak_q[EW-1] || (peak_q == '0);
	assign div_last    = (cnt_q == CNT_W'(FRACTION_BITS));
	assign halt_set    = (quo_q >= limit_q) && !halt_q;
	assign worst_d     = (quo_q > worst_q) ? quo_q : worst_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddt_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = ddt_pkg::ST_CMP;
			end
			ddt_pkg::ST_CMP:  state_d = ddt_pkg::ST_DIFF;
			ddt_pkg::ST_DIFF: begin
				state_d = peak_nonpos ? ddt_pkg::ST_FIN : ddt_pkg::ST_SAT;
			end
			ddt_pkg::ST_SAT: begin
				state_d = borrow ? ddt_pkg::ST_DIV : ddt_pkg::ST_FIN;
			end
			ddt_pkg::ST_DIV: begin
				if (div_last) state_d = ddt_pkg::ST_FIN;
			end
			ddt_pkg::ST_FIN: begin
				if (fin_go) state_d = ddt_pkg::ST_IDLE;
			end
			default: state_d = ddt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		fin_go   = 1'b0;
		op_a     = rem_q;
		op_b     = peak_q;
		case (state_q)
			ddt_pkg::ST_IDLE: s_tready = 1'b1;
			ddt_pkg::ST_CMP: begin
				// signed compare through offset binary
				op_a = peak_q ^ SIGN_BIT;
				op_b = sample_q ^ SIGN_BIT;
			end
			ddt_pkg::ST_DIFF: begin
				op_a = peak_q;
				op_b = sample_q;
			end
			ddt_pkg::ST_SAT: begin
				op_a = rem_q;
				op_b = {peak_q[EW-2:0], 1'b0};
			end
			ddt_pkg::ST_DIV: begin
				op_a = rem_q;
				op_b = peak_q;
			end
			ddt_pkg::ST_FIN: fin_go = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ddt_pkg::ST_IDLE;
			peak_q     <= '0;
			worst_q    <= '0;
			halt_q     <= 1'b0;
			limit_q    <= LIMIT_RST;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ddt_pkg::REG_INITIAL_EQUITY: begin
						peak_q  <= cfg_data[EW-1:0];
						worst_q <= '0;
						halt_q  <= 1'b0;
					end
					ddt_pkg::REG_DRAWDOWN_LIMIT: limit_q <= cfg_data[RW-1:0];
					default: limit_q <= limit_q;
				endcase
			end else begin
				if (state_q == ddt_pkg::ST_CMP && borrow) peak_q <= sample_q;
				if (fin_go) begin
					worst_q <= worst_d;
					halt_q  <= halt_q | halt_set;
				end
			end
			if (state_q == ddt_pkg::ST_SAT) cnt_q <= '0;
			else if (state_q == ddt_pkg::ST_DIV) cnt_q <= cnt_q + CNT_W'(1);
			if (fin_go) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) sample_q <= s_tdata[EW-1:0];
		case (state_q)
			ddt_pkg::ST_DIFF: begin
				rem_q <= sub[EW-1:0];
				quo_q <= '0;
			end
			ddt_pkg::ST_SAT: begin
				if (!borrow) quo_q <= '1;
			end
			ddt_pkg::ST_DIV: begin
				// restore one quotient bit, then shift the remainder
				rem_q <= borrow ? {rem_q[EW-2:0], 1'b0} : {sub[EW-2:0], 1'b0};
				quo_q <= {quo_q[RW-2:0], !borrow};
			end
			default: rem_q <= rem_q;
		endcase
		if (fin_go) begin
			out_peak_q   <= peak_q;
			out_dd_q     <= quo_q;
			out_worst_q  <= worst_d;
			out_halted_q <= halt_q | halt_set;
			out_now_q    <= halt_set;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_now_q, out_halted_q, out_worst_q, out_dd_q, out_peak_q});

	`ASSERT_CLK(a_now_implies_halted, m_tvalid && out_now_q |-> out_halted_q, "halt_now without halted")
	`ASSERT_CLK(a_dd_within_worst, m_tvalid |-> out_dd_q <= out_worst_q, "drawdown above worst")
	`ASSERT_CLK(a_worst_monotonic, !cfg_we |=> worst_q >= $past(worst_q), "worst drawdown fell")
	`ASSERT_NEVER(a_div_positive_peak, state_q == ddt_pkg::ST_DIV && peak_nonpos, "divide by non-positive peak")

endmodule
